@@ sv/msd_pkg.sv @@
// Shared types, constants and helpers of the multichannel spike detector.
// No dependencies; msd_bank, msd_detect and the top level import this package.
package msd_pkg;

    // Channel count and neighbour fan-in
    localparam int CHANNELS     = 128;
    localparam int NEIGHBOURS   = 4;
    localparam int PORTS        = NEIGHBOURS + 1;
    localparam int CH_W         = $clog2(CHANNELS);
    localparam int CHAN_FIELD_W = 7;
    localparam int DATA_W       = 32;
    localparam int REFR_W       = 3;

    // Detector state codes
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_FALL = 2'd1;
    localparam logic [1:0] ST_RISE = 2'd2;

    localparam logic [REFR_W-1:0] REFR_LEN_RESET = 3'd7;

    // One memory word per channel: both sample rows plus detector state
    typedef struct packed {
        logic [1:0][DATA_W-1:0] rows;
        logic signed [DATA_W-1:0] run_min;
        logic [1:0]               det_state;
        logic                     refr_active;
        logic [REFR_W-1:0]        refr_count;
    } t_chan_word;

    localparam int WORD_W = $bits(t_chan_word);

    // Reduce a channel field modulo CHANNELS by restoring subtraction
    function automatic logic [CH_W-1:0] chan_reduce(input logic [CHAN_FIELD_W-1:0] v);
        logic [15:0] r;
        r = 16'(v);
        for (int k = CHAN_FIELD_W - 1; k >= 0; k--) begin
            if (r >= 16'(CHANNELS << k)) begin
                r = r - 16'(CHANNELS << k);
            end
        end
        return r[CH_W-1:0];
    endfunction

endpackage

@@ sv/msd_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module msd_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write one word, read one word into a registered output
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/msd_bank.sv @@
// Replicated channel-word memory: one replica per read address, per-channel
// valid bits for reset, and forwarding of the last write. Uses msd_pkg, msd_ram.
module msd_bank import msd_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [PORTS-1:0][CH_W-1:0]  i_rd_addr,
    input  logic                        i_wr_en,
    input  logic [CH_W-1:0]             i_wr_addr,
    input  t_chan_word                  i_wr_word,
    output t_chan_word [PORTS-1:0]      o_rd_word
);

    logic [WORD_W-1:0]          ram_q [PORTS];
    logic [CHANNELS-1:0]        r_valid;
    logic                       r_fw_valid;
    logic [CH_W-1:0]            r_fw_addr;
    t_chan_word                 r_fw_word;
    logic [PORTS-1:0][CH_W-1:0] r_rd_addr;

    // One replica per read address, all written with the same word
    for (genvar j = 0; j < PORTS; j++) begin : g_rep
        msd_ram #(
            .DEPTH (CHANNELS),
            .WIDTH (WORD_W)
        ) u_ram (
            .i_clk     (i_clk),
            .i_wr_en   (i_wr_en),
            .i_wr_addr (i_wr_addr),
            .i_wr_data (i_wr_word),
            .i_rd_en   (i_rd_en),
            .i_rd_addr (i_rd_addr[j]),
            .o_rd_data (ram_q[j])
        );
    end

    // Mark written channels, track whether a write is held for forwarding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_fw_valid <= 1'b0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
            r_fw_valid         <= 1'b1;
        end
    end

    // Hold the last write and the addresses of the pending read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_fw_addr <= i_wr_addr;
            r_fw_word <= i_wr_word;
        end
        if (i_rd_en) begin
            r_rd_addr <= i_rd_addr;
        end
    end

    // Resolve each read: forwarded word, stored word, or the reset word
    always_comb begin
        for (int j = 0; j < PORTS; j++) begin
            if (r_fw_valid && (r_fw_addr == r_rd_addr[j])) begin
                o_rd_word[j] = r_fw_word;
            end else if (r_valid[r_rd_addr[j]]) begin
                o_rd_word[j] = t_chan_word'(ram_q[j]);
            end else begin
                o_rd_word[j] = '0;
            end
        end
    end

endmodule

@@ sv/msd_detect.sv @@
// Per-item detection logic: refractory advance, neighbour minimum test,
// state machine step and running-minimum update. Uses msd_pkg.
module msd_detect import msd_pkg::*; (
    input  t_chan_word                          i_own,
    input  t_chan_word [NEIGHBOURS-1:0]         i_nbr_word,
    input  logic                                i_rd_row,
    input  logic [CH_W-1:0]                     i_chan,
    input  logic [NEIGHBOURS-1:0][CH_W-1:0]     i_nbr_chan,
    input  logic signed [DATA_W-1:0]            i_threshold,
    input  logic signed [DATA_W-1:0]            i_cur,
    input  logic [REFR_W-1:0]                   i_refr_len,
    output t_chan_word                          o_word,
    output logic [DATA_W-1:0]                   o_value
);

    logic signed [DATA_W-1:0] prev;
    logic signed [DATA_W-1:0] nb_val;
    logic [REFR_W-1:0]        cnt_inc;
    logic                     adv_active;
    logic [REFR_W-1:0]        adv_count;
    logic                     nb_act;
    logic [NEIGHBOURS-1:0]    nb_ok;
    logic                     pivotal;
    logic                     below;
    logic                     falling;

    // Advance the channel's refractory counter
    always_comb begin
        prev       = $signed(i_own.rows[i_rd_row]);
        cnt_inc    = i_own.refr_count + 3'd1;
        adv_active = i_own.refr_active;
        adv_count  = i_own.refr_count;
        if (i_own.refr_active) begin
            if (cnt_inc == i_refr_len) begin
                adv_count  = '0;
                adv_active = 1'b0;
            end else begin
                adv_count = cnt_inc;
            end
        end
    end

    // Test the previous sample against every neighbour
    always_comb begin
        for (int i = 0; i < NEIGHBOURS; i++) begin
            nb_val = $signed(i_nbr_word[i].rows[i_rd_row]);
            // a neighbour equal to the channel sees the advanced refractory flag
            nb_act = (i_nbr_chan[i] == i_chan) ? adv_active : i_nbr_word[i].refr_active;
            nb_ok[i] = (prev <= $signed(i_nbr_word[i].run_min)) && (prev <= nb_val)
                       && !nb_act;
        end
        pivotal = &nb_ok;
    end

    // Step the state machine and build the write-back word
    always_comb begin
        below   = prev < i_threshold;
        falling = prev > i_cur;
        o_word  = i_own;
        o_word.rows[~i_rd_row] = i_cur;
        o_word.refr_active     = adv_active;
        o_word.refr_count      = adv_count;
        o_value = i_own.rows[i_rd_row];
        case (i_own.det_state)
            ST_FALL: begin
                if (below && falling) begin
                    o_word.det_state = ST_FALL;
                end else if (below) begin
                    o_word.det_state = ST_RISE;
                    if (pivotal) begin
                        o_value[0]         = 1'b1;
                        o_word.refr_active = 1'b1;
                    end
                end else begin
                    o_word.det_state = ST_IDLE;
                end
            end
            ST_RISE: begin
                if (below && falling) begin
                    o_word.det_state = ST_FALL;
                end else if (below) begin
                    o_word.det_state = ST_RISE;
                end else begin
                    o_word.det_state = ST_IDLE;
                end
            end
            default: begin
                o_word.det_state = below ? ST_FALL : ST_IDLE;
            end
        endcase
        // lower the minimum below threshold, clear it at or above
        if (i_cur < i_threshold) begin
            if (i_cur < $signed(i_own.run_min)) begin
                o_word.run_min = i_cur;
            end
        end else begin
            o_word.run_min = '0;
        end
    end

endmodule

@@ sv/multichannel_spike_detector.sv @@
// An accepted word is captured into the stage-1 registers; when stage 1 advances, a word
// with nonzero time is loaded into the output register, which raises o_out_valid.
// Throughput: one word per cycle unless the output stalls, set by the read-modify-write
// of the replicated channel memory, with the last write forwarded to the next read.
// Items with time zero update state and give no output word.
// Reset (i_rst_n low, synchronous): empties the pipeline, sets refractory
// length to 7 and marks every channel word as zero via valid bits; no clearing pass.
module multichannel_spike_detector import msd_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [DATA_W-1:0]          i_time_index,
    input  logic [CHAN_FIELD_W-1:0]    i_channel,
    input  logic [CHAN_FIELD_W-1:0]    i_neighbour_a,
    input  logic [CHAN_FIELD_W-1:0]    i_neighbour_b,
    input  logic [CHAN_FIELD_W-1:0]    i_neighbour_c,
    input  logic [CHAN_FIELD_W-1:0]    i_neighbour_d,
    input  logic signed [DATA_W-1:0]   i_threshold,
    input  logic signed [DATA_W-1:0]   i_sample_value,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [CHAN_FIELD_W-1:0]    o_out_channel,
    output logic [DATA_W-1:0]          o_out_time,
    output logic signed [DATA_W-1:0]   o_out_value,
    output logic [CHAN_FIELD_W-1:0]    o_out_neighbour_a,
    output logic [CHAN_FIELD_W-1:0]    o_out_neighbour_b,
    output logic [CHAN_FIELD_W-1:0]    o_out_neighbour_c,
    output logic [CHAN_FIELD_W-1:0]    o_out_neighbour_d,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [REFR_W-1:0]          i_cfg_data
);

    logic                                    in_accept;
    logic                                    s1_adv;
    logic                                    s1_emit;
    logic                                    n_s1_valid;
    logic                                    n_out_valid;
    logic [NEIGHBOURS-1:0][CHAN_FIELD_W-1:0] in_nbr;
    logic [PORTS-1:0][CH_W-1:0]              rd_addr;
    t_chan_word [PORTS-1:0]                  rd_word;
    t_chan_word                              wb_word;
    logic [DATA_W-1:0]                       det_value;

    logic [REFR_W-1:0]                       r_refr_len;
    logic                                    r_s1_valid;
    logic [DATA_W-1:0]                       r_s1_time;
    logic [CHAN_FIELD_W-1:0]                 r_s1_chan;
    logic [NEIGHBOURS-1:0][CHAN_FIELD_W-1:0] r_s1_nbr;
    logic [CH_W-1:0]                         r_s1_ch_idx;
    logic [NEIGHBOURS-1:0][CH_W-1:0]         r_s1_nb_idx;
    logic signed [DATA_W-1:0]                r_s1_thr;
    logic signed [DATA_W-1:0]                r_s1_cur;
    logic                                    r_out_valid;
    logic [CHAN_FIELD_W-1:0]                 r_out_chan;
    logic [DATA_W-1:0]                       r_out_time;
    logic [DATA_W-1:0]                       r_out_value;
    logic [NEIGHBOURS-1:0][CHAN_FIELD_W-1:0] r_out_nbr;

    // Handshakes: stage 1 moves on when its word needs no slot or the slot frees
    assign s1_emit    = r_s1_time != '0;
    assign s1_adv     = r_s1_valid && (!s1_emit || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_accept  = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // Reduce channel numbers and issue the memory reads
    assign in_nbr = {i_neighbour_d, i_neighbour_c, i_neighbour_b, i_neighbour_a};
    always_comb begin
        rd_addr[0] = chan_reduce(i_channel);
        for (int i = 0; i < NEIGHBOURS; i++) begin
            rd_addr[i+1] = chan_reduce(in_nbr[i]);
        end
    end

    msd_bank u_bank (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_accept),
        .i_rd_addr (rd_addr),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_ch_idx),
        .i_wr_word (wb_word),
        .o_rd_word (rd_word)
    );

    msd_detect u_detect (
        .i_own       (rd_word[0]),
        .i_nbr_word  (rd_word[PORTS-1:1]),
        .i_rd_row    (~r_s1_time[0]),
        .i_chan      (r_s1_ch_idx),
        .i_nbr_chan  (r_s1_nb_idx),
        .i_threshold (r_s1_thr),
        .i_cur       (r_s1_cur),
        .i_refr_len  (r_refr_len),
        .o_word      (wb_word),
        .o_value     (det_value)
    );

    // Next-state of the pipeline valid flags
    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_accept) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (s1_adv && s1_emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_refr_len  <= REFR_LEN_RESET;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_refr_len <= i_cfg_data;
            end
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Capture the accepted word into stage 1; drop bit 0 of the sample
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_time   <= i_time_index;
            r_s1_chan   <= i_channel;
            r_s1_nbr    <= in_nbr;
            r_s1_ch_idx <= rd_addr[0];
            r_s1_nb_idx <= rd_addr[PORTS-1:1];
            r_s1_thr    <= i_threshold;
            r_s1_cur    <= {i_sample_value[DATA_W-1:1], 1'b0};
        end
    end

    // Load the output word
    always_ff @(posedge i_clk) begin
        if (s1_adv && s1_emit) begin
            r_out_chan  <= r_s1_chan;
            r_out_time  <= r_s1_time - 32'd1;
            r_out_value <= det_value;
            r_out_nbr   <= r_s1_nbr;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_channel     = r_out_chan;
    assign o_out_time        = r_out_time;
    assign o_out_value       = $signed(r_out_value);
    assign o_out_neighbour_a = r_out_nbr[0];
    assign o_out_neighbour_b = r_out_nbr[1];
    assign o_out_neighbour_c = r_out_nbr[2];
    assign o_out_neighbour_d = r_out_nbr[3];

endmodule

@@ sv/msd_checker.sv @@
// Port-level checks of the spike detector over time, bound to the top level.
// Depends on multichannel_spike_detector port names only.
module msd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [6:0]  o_out_channel,
    input logic [31:0] o_out_time,
    input logic [31:0] o_out_value
);

    // Hold a stalled output word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_value)
            && $stable(o_out_time) && $stable(o_out_channel))
        else $error("output word changed while stalled");

    // Time zero never emits, so the emitted time never wraps to all ones
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_time != 32'hFFFF_FFFF)
        else $error("emitted time wrapped");

    // With the output slot empty the pipeline must take a new word
    a_drain_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    // Leave reset with no output word
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind multichannel_spike_detector msd_checker u_msd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_out_channel (o_out_channel),
    .o_out_time    (o_out_time),
    .o_out_value   (o_out_value)
);
